// ----- src/mm3_pkg.sv -----
// ----------------------------------------------------------------------------
// mm3_pkg
// Shared types and constants of the MurmurHash3 x86_32 stream hash core.
// ----------------------------------------------------------------------------
package mm3_pkg;

    localparam logic [31:0] C1 = 32'hCC9E2D51;
    localparam logic [31:0] C2 = 32'h1B873593;
    localparam logic [31:0] N  = 32'hE6546B64;
    localparam logic [31:0] F1 = 32'h85EBCA6B;
    localparam logic [31:0] F2 = 32'hC2B2AE35;

    localparam logic [2:0] NB_NONE = 3'd0;
    localparam logic [2:0] NB_FULL = 3'd4;

    // One classified beat, as queued between the front and the back.
    typedef struct packed {
        logic [31:0] word;   // tail bytes above the count already cleared
        logic [2:0]  nb;     // byte count, clamped to 0..4
        logic        last;   // final beat of the message
        logic        err;    // a partial beat was dropped in this message
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_FOLD,
        S_FIN1,
        S_FIN2,
        S_EMIT
    } t_back_state;

endpackage

// ----- src/mm3_front.sv -----
// ----------------------------------------------------------------------------
// mm3_front
// Accepts input beats, clamps the byte count, masks tail bytes, drops partial
// beats that are not last and tracks the order error of the message.
// ----------------------------------------------------------------------------
module mm3_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [31:0]          i_data_word,
    input  logic [2:0]           i_valid_bytes,
    input  logic                 i_last_word,
    input  logic                 i_q_full,
    output logic                 o_push,
    output mm3_pkg::t_entry      o_entry
);

    logic       r_err;
    logic       n_err;
    logic [2:0] nb;
    logic       accept;
    logic       drop;

    always_comb begin
        case (i_valid_bytes) inside
            [3'd5:3'd7]: nb = mm3_pkg::NB_FULL;
            default:     nb = i_valid_bytes;
        endcase
    end

    always_comb begin
        case (nb)
            3'd0:    o_entry.word = 32'h0000_0000;
            3'd1:    o_entry.word = {24'h00_0000, i_data_word[7:0]};
            3'd2:    o_entry.word = {16'h0000, i_data_word[15:0]};
            3'd3:    o_entry.word = {8'h00, i_data_word[23:0]};
            default: o_entry.word = i_data_word;
        endcase
        o_entry.nb   = nb;
        o_entry.last = i_last_word;
        o_entry.err  = r_err;
    end

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign drop       = !i_last_word && (nb != mm3_pkg::NB_FULL);
    assign o_push     = accept && !drop;

    always_comb begin
        n_err = r_err;
        if (accept) begin
            if (drop) begin
                n_err = 1'b1;
            end else if (i_last_word) begin
                n_err = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= 1'b0;
        end else begin
            r_err <= n_err;
        end
    end

endmodule

// ----- src/mm3_queue.sv -----
// ----------------------------------------------------------------------------
// mm3_queue
// Short first-in first-out queue of classified beats between front and back.
// ----------------------------------------------------------------------------
module mm3_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mm3_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output mm3_pkg::t_entry o_entry
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mm3_pkg::t_entry  r_mem [DEPTH];
    logic [IDX_W-1:0] r_wptr;
    logic [IDX_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == IDX_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == IDX_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- src/mm3_back.sv -----
// ----------------------------------------------------------------------------
// mm3_back
// Sequencer around one shared 32x32 multiplier: scrambles each beat, folds it
// into the running hash, finalises on the last beat and holds the result.
// ----------------------------------------------------------------------------
module mm3_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_seed_we,
    input  logic [31:0]     i_seed_wdata,
    input  logic            i_q_empty,
    input  mm3_pkg::t_entry i_entry,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [31:0]     o_hash,
    output logic            o_order_error
);

    mm3_pkg::t_back_state r_state;
    mm3_pkg::t_back_state n_state;

    logic [31:0] r_seed;
    logic [31:0] r_hash;
    logic [31:0] r_count;
    logic [31:0] r_acc;
    logic [31:0] r_word;
    logic [2:0]  r_nb;
    logic        r_last;
    logic        r_err;
    logic        r_out_valid;
    logic [31:0] r_out_hash;
    logic        r_out_err;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_p;
    logic        out_free;
    logic        load_out;
    logic [31:0] h_x;
    logic [31:0] h_r;
    logic [31:0] h_new;
    logic [31:0] count_new;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mm3_pkg::S_IDLE: if (!i_q_empty) n_state = mm3_pkg::S_MUL1;
            mm3_pkg::S_MUL1: n_state = mm3_pkg::S_MUL2;
            mm3_pkg::S_MUL2: n_state = mm3_pkg::S_FOLD;
            mm3_pkg::S_FOLD: n_state = r_last ? mm3_pkg::S_FIN1 : mm3_pkg::S_IDLE;
            mm3_pkg::S_FIN1: n_state = mm3_pkg::S_FIN2;
            mm3_pkg::S_FIN2: n_state = mm3_pkg::S_EMIT;
            mm3_pkg::S_EMIT: if (out_free) n_state = mm3_pkg::S_IDLE;
            default:         n_state = mm3_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: pop, result load and multiplier operands
    always_comb begin
        o_pop    = 1'b0;
        load_out = 1'b0;
        mul_a    = r_word;
        mul_b    = mm3_pkg::C1;
        case (r_state)
            mm3_pkg::S_IDLE: o_pop = !i_q_empty;
            mm3_pkg::S_MUL1: begin
                mul_a = r_word;
                mul_b = mm3_pkg::C1;
            end
            mm3_pkg::S_MUL2: begin
                mul_a = {r_acc[16:0], r_acc[31:17]};
                mul_b = mm3_pkg::C2;
            end
            mm3_pkg::S_FIN1: begin
                mul_a = r_acc ^ {16'h0000, r_acc[31:16]};
                mul_b = mm3_pkg::F1;
            end
            mm3_pkg::S_FIN2: begin
                mul_a = r_acc ^ {13'h0000, r_acc[31:13]};
                mul_b = mm3_pkg::F2;
            end
            mm3_pkg::S_EMIT: load_out = out_free;
            default: begin
                o_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Fold: full beat rotates and takes times five plus N, tail only xors, empty beat keeps the hash
    always_comb begin
        h_x = r_hash ^ r_acc;
        h_r = {h_x[18:0], h_x[31:19]};
        case (r_nb)
            mm3_pkg::NB_FULL: h_new = h_r + {h_r[29:0], 2'b00} + mm3_pkg::N;
            mm3_pkg::NB_NONE: h_new = r_hash;
            default:          h_new = h_x;
        endcase
        count_new = r_count + {29'h0000_0000, r_nb};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mm3_pkg::S_IDLE;
            r_seed      <= 32'h0000_0000;
            r_hash      <= 32'h0000_0000;
            r_count     <= 32'h0000_0000;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_seed_we) begin
                r_seed <= i_seed_wdata;
                if (r_count == 32'h0000_0000) begin
                    r_hash <= i_seed_wdata;
                end
            end
            if (r_state == mm3_pkg::S_FOLD) begin
                if (r_last) begin
                    r_hash  <= r_seed;
                    r_count <= 32'h0000_0000;
                end else begin
                    r_hash  <= h_new;
                    r_count <= count_new;
                end
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word <= i_entry.word;
            r_nb   <= i_entry.nb;
            r_last <= i_entry.last;
            r_err  <= i_entry.err;
        end
        case (r_state)
            mm3_pkg::S_MUL1,
            mm3_pkg::S_MUL2,
            mm3_pkg::S_FIN1,
            mm3_pkg::S_FIN2: r_acc <= mul_p;
            mm3_pkg::S_FOLD: r_acc <= h_new ^ count_new;
            default:         r_acc <= r_acc;
        endcase
        if (load_out) begin
            r_out_hash <= r_acc ^ {16'h0000, r_acc[31:16]};
            r_out_err  <= r_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hash        = r_out_hash;
    assign o_order_error = r_out_err;

endmodule

// ----- src/murmur3_32_stream_hash_core.sv -----
// Sequence: a beat is registered in the queue, then the back steps through
//   S_IDLE, S_MUL1, S_MUL2 and S_FOLD, a last beat on through S_FIN1, S_FIN2
//   and S_EMIT to o_out_valid. The back, with its shared multiplier, takes no
//   new beat until done with the last; a dropped partial beat is never queued.
// Reset (i_rst_n, synchronous, active low): seed and hash to zero, count and
//   error cleared, queue emptied, no result pending.
// ----------------------------------------------------------------------------
// murmur3_32_stream_hash_core
// MurmurHash3 x86_32 over a stream of little-endian 32-bit beats. The front
// classifies each beat and drops partial beats that come before the last; a
// short queue decouples it from the back, which mixes, folds and finalises
// with a single multiplier and holds the result in an output register.
// ----------------------------------------------------------------------------
module murmur3_32_stream_hash_core #(
    parameter int DEPTH = 4   // queue entries, 2 or more
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // seed register write
    input  logic        i_seed_we,
    input  logic [31:0] i_seed_wdata,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_data_word,
    input  logic [2:0]  i_valid_bytes,
    input  logic        i_last_word,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash,
    output logic        o_order_error
);

    mm3_pkg::t_entry front_entry;
    mm3_pkg::t_entry head_entry;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    // Front: clamp and mask each beat, drop partial beats, track the error
    mm3_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_data_word   (i_data_word),
        .i_valid_bytes (i_valid_bytes),
        .i_last_word   (i_last_word),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_entry       (front_entry)
    );

    // Queue: hold classified beats while the back is busy
    mm3_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_entry (head_entry)
    );

    // Back: scramble, fold, finalise; seed lives here with the running hash
    mm3_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_seed_we     (i_seed_we),
        .i_seed_wdata  (i_seed_wdata),
        .i_q_empty     (q_empty),
        .i_entry       (head_entry),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_hash        (o_hash),
        .o_order_error (o_order_error)
    );

endmodule
